### rtl/core/hiq_pkg.sv
// shared types, constants and the quality table of the homopolymer indel quality block
`timescale 1ns / 1ps
`default_nettype none

package hiq_pkg;

    // reference store geometry
    localparam int REF_DEPTH  = 65536;
    localparam int MAX_CHUNK  = 64;
    localparam int ADDR_W     = $clog2(REF_DEPTH);
    // cursor and lookup position, room for the saturated cursor plus one chunk
    localparam int CUR_W      = $clog2(REF_DEPTH + MAX_CHUNK + 2);

    // run lengths
    localparam int RUN_W      = 5;
    localparam int RUN_SAT    = 19;
    localparam int RUN_LIMIT  = 18;

    // field widths
    localparam int LEN_W      = 7;
    localparam int CHAR_W     = 8;
    localparam int BASE_W     = 8;
    localparam int POS_W      = 16;
    localparam int CMD_W      = 2;
    localparam int OP_W       = 4;
    localparam int S_DATA_W   = 40;

    // job queue between front and back
    localparam int JOBQ_DEPTH = 4;
    localparam int JOBQ_AW    = $clog2(JOBQ_DEPTH);

    localparam logic [CHAR_W-1:0] QUAL_BANG = 8'h21;
    localparam logic [CHAR_W-1:0] QUAL_ZERO = 8'h00;

    typedef enum logic [CMD_W-1:0] {
        CMD_REF_BASE   = 2'd0,
        CMD_READ_START = 2'd1,
        CMD_CIGAR      = 2'd2
    } t_cmd;

    typedef enum logic [OP_W-1:0] {
        OP_MATCH = 4'd0,
        OP_INS   = 4'd1,
        OP_DEL   = 4'd2,
        OP_SOFT  = 4'd4,
        OP_HARD  = 4'd5,
        OP_EQUAL = 4'd7,
        OP_DIFF  = 4'd8
    } t_cigar_op;

    typedef enum logic [1:0] {
        JOB_LOOKUP,
        JOB_BANG,
        JOB_ERROR
    } t_job_kind;

    typedef enum logic {
        F_TAKE,
        F_HEAD
    } t_front_state;

    typedef enum logic {
        B_IDLE,
        B_RUN
    } t_back_state;

    // one unit of back-end work: count results starting at lookup position pos
    typedef struct packed {
        t_job_kind               kind;
        logic [LEN_W-1:0]        count;
        logic [CUR_W-1:0]        pos;
    } t_hiq_job;

    // write port of the run length store
    typedef struct packed {
        logic                    en;
        logic [ADDR_W-1:0]       addr;
        logic [RUN_W-1:0]        data;
    } t_store_wr;

    // quality character for a run length, out of range gives '!'
    function automatic logic [CHAR_W-1:0] qual_lookup(input logic [RUN_W-1:0] run);
        logic [CHAR_W-1:0] q;
        case (run)
            5'd1, 5'd2, 5'd3: q = 8'h4d;  // M
            5'd4:             q = 8'h4c;  // L
            5'd5:             q = 8'h4b;  // K
            5'd6:             q = 8'h45;  // E
            5'd7:             q = 8'h43;  // C
            5'd8:             q = 8'h40;  // @
            5'd9:             q = 8'h3d;  // =
            5'd10:            q = 8'h3c;  // <
            5'd11:            q = 8'h3b;  // ;
            5'd12:            q = 8'h3a;  // :
            5'd13:            q = 8'h39;  // 9
            5'd14, 5'd15:     q = 8'h38;  // 8
            5'd16, 5'd17:     q = 8'h37;  // 7
            5'd18:            q = 8'h36;  // 6
            default:          q = QUAL_BANG;
        endcase
        return q;
    endfunction

endpackage

`default_nettype wire

### rtl/core/hiq_store.sv
// run length store: one write port, one registered read port
`timescale 1ns / 1ps
`default_nettype none

module hiq_store
    import hiq_pkg::*;
(
    input  wire logic              i_clk,
    input  wire t_store_wr         i_wr,
    input  wire logic              i_rd_en,
    input  wire logic [ADDR_W-1:0] i_rd_addr,
    output logic [RUN_W-1:0]       o_rd_data
);

    logic [RUN_W-1:0] r_mem [REF_DEPTH];
    logic [RUN_W-1:0] r_rd_data;

    // write side
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
    end

    // registered read
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

### rtl/core/hiq_queue.sv
// short job queue between the front and the back
`timescale 1ns / 1ps
`default_nettype none

module hiq_queue
    import hiq_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_push,
    input  wire t_hiq_job i_job,
    input  wire logic     i_pop,
    output t_hiq_job      o_job,
    output logic          o_empty,
    output logic          o_full
);

    t_hiq_job               r_mem [JOBQ_DEPTH];
    logic [JOBQ_AW-1:0]     r_wp;
    logic [JOBQ_AW-1:0]     r_rp;
    logic [JOBQ_AW:0]       r_cnt;
    logic [JOBQ_AW:0]       n_cnt;

    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == (JOBQ_AW+1)'(JOBQ_DEPTH));
    assign o_job   = r_mem[r_rp];

    // occupancy
    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (i_pop && !i_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    // pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
        end
    end

    // entries
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

endmodule

`default_nettype wire

### rtl/core/hiq_front.sv
// front end: takes input transfers, loads the reference store, turns cigar chunks into jobs
`timescale 1ns / 1ps
`default_nettype none

module hiq_front
    import hiq_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire logic [S_DATA_W-1:0] i_in_data,
    input  wire logic [CMD_W-1:0]    i_in_user,
    input  wire logic                i_in_last,
    input  wire logic                i_back_idle,
    input  wire logic                i_q_empty,
    input  wire logic                i_q_full,
    output logic                     o_q_push,
    output t_hiq_job                 o_q_job,
    output t_store_wr                o_store_wr,
    output logic [CUR_W-1:0]         o_ref_length
);

    t_front_state        r_state;
    t_front_state        n_state;
    logic [CUR_W-1:0]    r_ref_length;
    logic [ADDR_W-1:0]   r_run_start;
    logic [RUN_W-1:0]    r_run_count;
    logic [BASE_W-1:0]   r_run_base;
    logic [CUR_W-1:0]    r_cursor;
    logic                r_read_active;

    logic                w_first;
    logic [BASE_W-1:0]   w_base;
    logic [POS_W-1:0]    w_rpos;
    logic                w_pp;
    logic [OP_W-1:0]     w_op;
    logic [LEN_W-1:0]    w_len;
    logic [LEN_W-1:0]    w_len_c;
    logic [CUR_W-1:0]    w_pos;
    logic                w_in_range;
    logic                w_extend;
    logic [RUN_W-1:0]    w_run_inc;
    logic                w_need_job;
    logic                w_op_err;
    t_job_kind           w_kind;
    logic [LEN_W-1:0]    w_adv;
    logic [CUR_W-1:0]    w_cur_sum;
    logic [CUR_W-1:0]    w_cur_next;
    logic [CUR_W-1:0]    w_start_cur;
    logic                w_cigar_job;
    logic                w_take;

    // field unpack
    assign w_first = i_in_data[0];
    assign w_base  = i_in_data[8:1];
    assign w_rpos  = i_in_data[24:9];
    assign w_pp    = i_in_data[25];
    assign w_op    = i_in_data[29:26];
    assign w_len   = i_in_data[36:30];

    assign w_len_c = (w_len > LEN_W'(MAX_CHUNK)) ? LEN_W'(MAX_CHUNK) : w_len;

    // reference load position and run tracking
    assign w_pos      = w_first ? '0 : r_ref_length;
    assign w_in_range = (w_pos < CUR_W'(REF_DEPTH));
    assign w_extend   = (w_pos != '0) && (w_base == r_run_base);
    assign w_run_inc  = (r_run_count < RUN_W'(RUN_SAT)) ? (r_run_count + 1'b1) : r_run_count;

    // cigar op decode
    always_comb begin
        w_need_job = 1'b0;
        w_op_err   = 1'b0;
        w_kind     = JOB_LOOKUP;
        w_adv      = '0;
        unique case (w_op)
            OP_MATCH, OP_EQUAL, OP_DIFF: begin
                w_need_job = (w_len_c != '0);
                w_adv      = w_len_c;
            end
            OP_INS, OP_SOFT: begin
                w_need_job = (w_len_c != '0);
                w_kind     = JOB_BANG;
            end
            OP_DEL: begin
                w_adv = w_len_c;
            end
            OP_HARD: begin
                w_adv = '0;
            end
            default: begin
                w_need_job = 1'b1;
                w_op_err   = 1'b1;
                w_kind     = JOB_ERROR;
            end
        endcase
    end

    // cursor advance, saturating at the store depth
    assign w_cur_sum   = r_cursor + CUR_W'(w_adv);
    assign w_cur_next  = (w_cur_sum > CUR_W'(REF_DEPTH)) ? CUR_W'(REF_DEPTH) : w_cur_sum;
    assign w_start_cur = (32'(w_rpos) > 32'(REF_DEPTH)) ? CUR_W'(REF_DEPTH) : CUR_W'(w_rpos);

    assign w_cigar_job = (i_in_user == CMD_CIGAR) && r_read_active && w_need_job;
    assign w_take      = i_in_valid && o_in_ready;

    // job for the back end
    always_comb begin
        o_q_job.kind  = w_kind;
        o_q_job.count = w_op_err ? LEN_W'(1) : w_len_c;
        o_q_job.pos   = r_cursor + 1'b1;
    end
    assign o_q_push = w_take && w_cigar_job;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            F_TAKE: begin
                if (w_take && (i_in_user == CMD_REF_BASE) && w_in_range && w_extend) begin
                    n_state = F_HEAD;
                end
            end
            F_HEAD: n_state = F_TAKE;
            default: n_state = F_TAKE;
        endcase
    end

    // fsm outputs: ready and store writes
    always_comb begin
        o_in_ready      = 1'b0;
        o_store_wr.en   = 1'b0;
        o_store_wr.addr = w_pos[ADDR_W-1:0];
        o_store_wr.data = RUN_W'(1);
        unique case (r_state)
            F_TAKE: begin
                // a base waits until every earlier lookup is done
                case (i_in_user)
                    CMD_REF_BASE: o_in_ready = i_back_idle && i_q_empty;
                    CMD_CIGAR:    o_in_ready = !w_cigar_job || !i_q_full;
                    default:      o_in_ready = 1'b1;
                endcase
                o_store_wr.en = i_in_valid && o_in_ready
                                && (i_in_user == CMD_REF_BASE) && w_in_range;
            end
            F_HEAD: begin
                // second write: refresh the length at the head of the run
                o_store_wr.en   = 1'b1;
                o_store_wr.addr = r_run_start;
                o_store_wr.data = r_run_count;
            end
            default: o_in_ready = 1'b0;
        endcase
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= F_TAKE;
            r_ref_length  <= '0;
            r_run_start   <= '0;
            r_run_count   <= '0;
            r_run_base    <= '0;
            r_cursor      <= '0;
            r_read_active <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_take) begin
                case (i_in_user)
                    CMD_REF_BASE: begin
                        if (w_in_range) begin
                            if (w_extend) begin
                                r_run_count <= w_run_inc;
                            end else begin
                                r_run_start <= w_pos[ADDR_W-1:0];
                                r_run_count <= RUN_W'(1);
                                r_run_base  <= w_base;
                            end
                            r_ref_length <= w_pos + 1'b1;
                        end
                    end
                    CMD_READ_START: begin
                        r_cursor      <= w_start_cur;
                        r_read_active <= w_pp;
                    end
                    CMD_CIGAR: begin
                        if (r_read_active) begin
                            r_cursor <= w_cur_next;
                            if (w_op_err || i_in_last) begin
                                r_read_active <= 1'b0;
                            end
                        end
                    end
                    default: r_read_active <= r_read_active;
                endcase
            end
        end
    end

    assign o_ref_length = r_ref_length;

endmodule

`default_nettype wire

### rtl/core/hiq_back.sv
// back end: walks each job one query base a cycle while there is buffer room, looks up the store, buffers results
`timescale 1ns / 1ps
`default_nettype none

module hiq_back
    import hiq_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_q_empty,
    output logic                   o_q_pop,
    input  wire t_hiq_job          i_q_job,
    input  wire logic [CUR_W-1:0]  i_ref_length,
    output logic                   o_rd_en,
    output logic [ADDR_W-1:0]      o_rd_addr,
    input  wire logic [RUN_W-1:0]  i_rd_data,
    output logic                   o_back_idle,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output logic [CHAR_W-1:0]      o_out_char,
    output logic                   o_out_last,
    output logic                   o_out_error
);

    t_back_state        r_state;
    t_back_state        n_state;
    t_job_kind          r_kind;
    logic [CUR_W-1:0]   r_pos;
    logic [LEN_W-1:0]   r_left;

    // one lookup in flight, waiting for store data
    logic               r_inf_v;
    t_job_kind          r_inf_kind;
    logic               r_inf_hit;
    logic               r_inf_last;

    // two-entry result buffer
    logic [CHAR_W-1:0]  r_fq_char [2];
    logic               r_fq_last [2];
    logic               r_fq_err  [2];
    logic               r_fq_wp;
    logic               r_fq_rp;
    logic [1:0]         r_fq_cnt;

    logic               w_pop_out;
    logic               w_room;
    logic               w_issue;
    logic [CHAR_W-1:0]  w_res_char;

    assign w_pop_out = (r_fq_cnt != 2'd0) && i_out_ready;
    // buffered plus in flight, less what leaves now, leaves room for one more
    assign w_room    = (({1'b0, r_fq_cnt} + 3'(r_inf_v) - 3'(w_pop_out)) < 3'd2);
    assign w_issue   = (r_state == B_RUN) && w_room;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            B_IDLE:  if (!i_q_empty) n_state = B_RUN;
            B_RUN:   if (w_issue && (r_left == LEN_W'(1))) n_state = B_IDLE;
            default: n_state = B_IDLE;
        endcase
    end

    // fsm outputs
    always_comb begin
        o_q_pop = 1'b0;
        o_rd_en = 1'b0;
        unique case (r_state)
            B_IDLE:  o_q_pop = !i_q_empty;
            B_RUN:   o_rd_en = w_issue && (r_kind == JOB_LOOKUP);
            default: o_q_pop = 1'b0;
        endcase
    end

    assign o_rd_addr   = r_pos[ADDR_W-1:0];
    assign o_back_idle = (r_state == B_IDLE) && !r_inf_v;

    // result character once store data is back
    always_comb begin
        unique case (r_inf_kind)
            JOB_LOOKUP: w_res_char = r_inf_hit ? qual_lookup(i_rd_data) : QUAL_BANG;
            JOB_BANG:   w_res_char = QUAL_BANG;
            default:    w_res_char = QUAL_ZERO;
        endcase
    end

    // sequencer and in-flight control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
            r_inf_v <= 1'b0;
        end else begin
            r_state <= n_state;
            r_inf_v <= w_issue;
        end
    end

    // job walk and in-flight payload
    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_kind <= i_q_job.kind;
            r_pos  <= i_q_job.pos;
            r_left <= i_q_job.count;
        end else if (w_issue) begin
            r_pos  <= r_pos + 1'b1;
            r_left <= r_left - 1'b1;
        end
        if (w_issue) begin
            r_inf_kind <= r_kind;
            r_inf_hit  <= (r_pos < i_ref_length);
            r_inf_last <= (r_left == LEN_W'(1));
        end
    end

    // result buffer control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fq_wp  <= 1'b0;
            r_fq_rp  <= 1'b0;
            r_fq_cnt <= 2'd0;
        end else begin
            if (r_inf_v) begin
                r_fq_wp <= !r_fq_wp;
            end
            if (w_pop_out) begin
                r_fq_rp <= !r_fq_rp;
            end
            r_fq_cnt <= r_fq_cnt + 2'(r_inf_v) - 2'(w_pop_out);
        end
    end

    // result buffer entries
    always_ff @(posedge i_clk) begin
        if (r_inf_v) begin
            r_fq_char[r_fq_wp] <= w_res_char;
            r_fq_last[r_fq_wp] <= r_inf_last;
            r_fq_err[r_fq_wp]  <= (r_inf_kind == JOB_ERROR);
        end
    end

    assign o_out_valid = (r_fq_cnt != 2'd0);
    assign o_out_char  = r_fq_char[r_fq_rp];
    assign o_out_last  = r_fq_last[r_fq_rp];
    assign o_out_error = r_fq_err[r_fq_rp];

    // result buffer never takes a result it has no room for
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_inf_v && !w_pop_out) |-> (r_fq_cnt != 2'd2))
        else $error("result buffer overflow");

    // store data is only expected after an issue in the run state
    a_inflight_from_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_inf_v |-> $past(r_state == B_RUN))
        else $error("lookup in flight without a running job");

    // an error result always closes its chunk
    a_error_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_error) |-> o_out_last)
        else $error("error result without last");

endmodule

`default_nettype wire

### rtl/core/homopolymer_indel_quality.sv
// top level of the homopolymer indel quality block
//
// input stream s_axis: tuser is the command (reference base, read start,
// cigar chunk), tlast marks the final cigar chunk of a read, tdata carries
// the remaining fields. output stream m_axis: one transfer per query base,
// tdata is the quality character, tlast closes the results of one chunk,
// tuser flags an unsupported cigar op.
// a cigar chunk passes the job queue, the back end job registers, the
// in-flight stage and the result buffer before its first result, then
// gives one result per cycle while m_axis_tready is high; the job queue
// holds 4 chunks, so the input keeps taking chunks while results drain.
// the rate is set by the back end stepping one base per cycle through
// the single read port of the run length store.
// a reference base that extends a run makes two store writes, the second
// from F_HEAD; it waits until all queued lookups are finished.
// read starts and chunks that give no results are taken without waiting.
// reset (i_rst_n low, synchronous) clears all control state; the run length
// store is not cleared and needs no clearing pass.
// when the receiver stalls, results wait in a two-entry buffer, then the
// back end and the job queue fill and s_axis_tready drops for chunks.
`timescale 1ns / 1ps
`default_nettype none

module homopolymer_indel_quality
    import hiq_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                s_axis_tvalid,
    output logic                     s_axis_tready,
    // ref_first[0], ref_base[8:1], read_position[24:9], proper_pair[25],
    // cigar_op[29:26], op_length[36:30], zero[39:37]
    input  wire logic [S_DATA_W-1:0] s_axis_tdata,
    // command[1:0]
    input  wire logic [CMD_W-1:0]    s_axis_tuser,
    input  wire logic                s_axis_tlast,
    output logic                     m_axis_tvalid,
    input  wire logic                m_axis_tready,
    // quality_char[7:0]
    output logic [CHAR_W-1:0]        m_axis_tdata,
    // op_error[0]
    output logic                     m_axis_tuser,
    output logic                     m_axis_tlast
);

    logic               w_back_idle;
    logic               w_q_empty;
    logic               w_q_full;
    logic               w_q_push;
    logic               w_q_pop;
    t_hiq_job           w_push_job;
    t_hiq_job           w_head_job;
    t_store_wr          w_store_wr;
    logic [CUR_W-1:0]   w_ref_length;
    logic               w_rd_en;
    logic [ADDR_W-1:0]  w_rd_addr;
    logic [RUN_W-1:0]   w_rd_data;

    // input side: reference load and chunk classification
    hiq_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (s_axis_tvalid),
        .o_in_ready   (s_axis_tready),
        .i_in_data    (s_axis_tdata),
        .i_in_user    (s_axis_tuser),
        .i_in_last    (s_axis_tlast),
        .i_back_idle  (w_back_idle),
        .i_q_empty    (w_q_empty),
        .i_q_full     (w_q_full),
        .o_q_push     (w_q_push),
        .o_q_job      (w_push_job),
        .o_store_wr   (w_store_wr),
        .o_ref_length (w_ref_length)
    );

    // jobs between the two sides
    hiq_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .i_job   (w_push_job),
        .i_pop   (w_q_pop),
        .o_job   (w_head_job),
        .o_empty (w_q_empty),
        .o_full  (w_q_full)
    );

    // run length store
    hiq_store u_store (
        .i_clk     (i_clk),
        .i_wr      (w_store_wr),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    // output side: per-base lookup and result buffer
    hiq_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_empty    (w_q_empty),
        .o_q_pop      (w_q_pop),
        .i_q_job      (w_head_job),
        .i_ref_length (w_ref_length),
        .o_rd_en      (w_rd_en),
        .o_rd_addr    (w_rd_addr),
        .i_rd_data    (w_rd_data),
        .o_back_idle  (w_back_idle),
        .o_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .o_out_char   (m_axis_tdata),
        .o_out_last   (m_axis_tlast),
        .o_out_error  (m_axis_tuser)
    );

endmodule

`default_nettype wire
